### rtl/lut3d_pkg.sv
package lut3d_pkg;

   // table geometry
   localparam int MAX_GRID   = 17;
   localparam int COLOR_BITS = 12;
   localparam int IDX_W      = 5;
   localparam int LUT_DEPTH  = MAX_GRID * MAX_GRID * MAX_GRID;
   localparam int ADDR_W     = $clog2(LUT_DEPTH);
   localparam int ENTRY_W    = 3 * COLOR_BITS;
   localparam int ADDR_SUM_W = 3 * IDX_W;
   localparam int DD_W       = 2 * IDX_W;

   // coordinate and weight formats
   localparam int COORD_W = 17;
   localparam int FRAC_W  = 16;
   localparam int W_W     = FRAC_W + 1;
   localparam int POS_W   = COORD_W + IDX_W;
   localparam logic [W_W-1:0] ONE_Q16 = W_W'(1) << FRAC_W;

   // blend pipeline widths
   localparam int P1_W       = COLOR_BITS + W_W;
   localparam int P2_W       = P1_W + W_W;
   localparam int SPLIT_W    = (P2_W + 1) / 2;
   localparam int HI_W       = P2_W - SPLIT_W;
   localparam int P3LO_W     = SPLIT_W + W_W;
   localparam int P3HI_W     = HI_W + W_W;
   localparam int FRAC_SHIFT = 3 * FRAC_W;
   localparam int ACC_LO_W   = FRAC_SHIFT + 1;
   localparam int ACC_HI_W   = P3HI_W + 3;
   localparam int FIN_W      = SPLIT_W + ACC_HI_W + 1;

   // opcodes
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ   = 2'd1;
   localparam logic [OP_W-1:0] OP_INTERP = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   // configuration
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_DIVISION = 1'b0;
   localparam logic [IDX_W-1:0] DIVISION_RESET = IDX_W'(MAX_GRID);

   typedef struct packed {
      logic       load_req;
      logic       split;
      logic       issue;
      logic       write;
      logic       interp;
      logic [2:0] corner;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic pipe_empty;
      logic out_free;
   } sts_type;

endpackage

### rtl/lut3d_ram.sv
module lut3d_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 4913
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/lut3d_dp.sv
module lut3d_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lut3d_pkg::cmd_type                   cmd,
   output lut3d_pkg::sts_type                   sts,
   input  logic [lut3d_pkg::IDX_W-1:0]          division,
   input  logic [lut3d_pkg::IDX_W-1:0]          red_index,
   input  logic [lut3d_pkg::IDX_W-1:0]          green_index,
   input  logic [lut3d_pkg::IDX_W-1:0]          blue_index,
   input  logic [lut3d_pkg::COLOR_BITS-1:0]     entry_red,
   input  logic [lut3d_pkg::COLOR_BITS-1:0]     entry_green,
   input  logic [lut3d_pkg::COLOR_BITS-1:0]     entry_blue,
   input  logic [lut3d_pkg::COORD_W-1:0]        rel_red,
   input  logic [lut3d_pkg::COORD_W-1:0]        rel_green,
   input  logic [lut3d_pkg::COORD_W-1:0]        rel_blue,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lut3d_pkg::COLOR_BITS-1:0]     out_red,
   output logic [lut3d_pkg::COLOR_BITS-1:0]     out_green,
   output logic [lut3d_pkg::COLOR_BITS-1:0]     out_blue
);

   logic [lut3d_pkg::IDX_W-1:0]   grid_d;
   logic [lut3d_pkg::IDX_W-1:0]   dm1;
   logic [lut3d_pkg::DD_W-1:0]    dd_ff, dd_in;

   logic [lut3d_pkg::IDX_W-1:0]   idx_ff [3];
   logic [lut3d_pkg::COORD_W-1:0] rel_ff [3];
   logic [lut3d_pkg::ENTRY_W-1:0] entry_ff;

   logic [lut3d_pkg::COORD_W-1:0] q [3];
   logic [lut3d_pkg::POS_W-1:0]   pos [3];
   logic [lut3d_pkg::IDX_W-1:0]   base [3];
   logic [lut3d_pkg::IDX_W-1:0]   sat [3];
   logic [lut3d_pkg::IDX_W-1:0]   lo_ff [3], lo_in [3];
   logic [lut3d_pkg::IDX_W-1:0]   hi_ff [3], hi_in [3];
   logic [lut3d_pkg::W_W-1:0]     wlo_ff [3], wlo_in [3];
   logic [lut3d_pkg::W_W-1:0]     whi_ff [3], whi_in [3];

   logic [lut3d_pkg::IDX_W-1:0]      ri, gi, bi;
   logic [lut3d_pkg::ADDR_SUM_W-1:0] addr_full;
   logic [lut3d_pkg::ADDR_W-1:0]     ram_addr;
   logic [lut3d_pkg::ENTRY_W-1:0]    rdata;

   logic       rd_v_ff, p1_v_ff, p2_v_ff, p3_v_ff;
   logic [2:0] k1_ff, k2_ff, k3_ff;
   logic [lut3d_pkg::W_W-1:0]      wr_sel, wg_sel, wb_sel;
   logic [lut3d_pkg::P1_W-1:0]     p1_ff [3], p1_in [3];
   logic [lut3d_pkg::P2_W-1:0]     p2_ff [3], p2_in [3];
   logic [lut3d_pkg::P3LO_W-1:0]   p3lo_ff [3], p3lo_in [3];
   logic [lut3d_pkg::P3HI_W-1:0]   p3hi_ff [3], p3hi_in [3];
   logic [lut3d_pkg::ACC_LO_W-1:0] acc_lo_ff [3];
   logic [lut3d_pkg::ACC_HI_W-1:0] acc_hi_ff [3];
   logic [lut3d_pkg::FIN_W-1:0]    fin [3];

   logic                            rsp_valid_ff;
   logic [lut3d_pkg::COLOR_BITS-1:0] out_ff [3], out_in [3];

   // effective grid size
   always_comb begin
      if (division < lut3d_pkg::IDX_W'(2)) begin
         grid_d = lut3d_pkg::IDX_W'(2);
      end else if (division > lut3d_pkg::IDX_W'(lut3d_pkg::MAX_GRID)) begin
         grid_d = lut3d_pkg::IDX_W'(lut3d_pkg::MAX_GRID);
      end else begin
         grid_d = division;
      end
      dm1   = grid_d - lut3d_pkg::IDX_W'(1);
      dd_in = lut3d_pkg::DD_W'(grid_d) * lut3d_pkg::DD_W'(grid_d);
   end

   always_ff @(posedge clock) begin
      dd_ff <= dd_in;
   end

   // capture transaction payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         idx_ff[0] <= red_index;
         idx_ff[1] <= green_index;
         idx_ff[2] <= blue_index;
         rel_ff[0] <= rel_red;
         rel_ff[1] <= rel_green;
         rel_ff[2] <= rel_blue;
         entry_ff  <= {entry_blue, entry_green, entry_red};
      end
   end

   // per-axis base index and weights, or saturated index
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         q[a]    = (rel_ff[a] > lut3d_pkg::COORD_W'(lut3d_pkg::ONE_Q16)) ?
                   lut3d_pkg::COORD_W'(lut3d_pkg::ONE_Q16) : rel_ff[a];
         pos[a]  = lut3d_pkg::POS_W'(q[a]) * lut3d_pkg::POS_W'(dm1);
         base[a] = pos[a][lut3d_pkg::FRAC_W+lut3d_pkg::IDX_W-1:lut3d_pkg::FRAC_W];
         sat[a]  = (idx_ff[a] > dm1) ? dm1 : idx_ff[a];
         if (!cmd.interp) begin
            lo_in[a]  = sat[a];
            hi_in[a]  = sat[a];
            wlo_in[a] = lut3d_pkg::ONE_Q16;
            whi_in[a] = '0;
         end else if (base[a] >= dm1) begin
            lo_in[a]  = dm1;
            hi_in[a]  = dm1;
            wlo_in[a] = lut3d_pkg::ONE_Q16;
            whi_in[a] = '0;
         end else begin
            lo_in[a]  = base[a];
            hi_in[a]  = base[a] + lut3d_pkg::IDX_W'(1);
            whi_in[a] = lut3d_pkg::W_W'(pos[a][lut3d_pkg::FRAC_W-1:0]);
            wlo_in[a] = lut3d_pkg::ONE_Q16 - whi_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.split) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         wlo_ff <= wlo_in;
         whi_ff <= whi_in;
      end
   end

   // corner address
   always_comb begin
      ri = cmd.corner[0] ? hi_ff[0] : lo_ff[0];
      gi = cmd.corner[1] ? hi_ff[1] : lo_ff[1];
      bi = cmd.corner[2] ? hi_ff[2] : lo_ff[2];
      addr_full = lut3d_pkg::ADDR_SUM_W'(ri)
                + lut3d_pkg::ADDR_SUM_W'(gi) * lut3d_pkg::ADDR_SUM_W'(grid_d)
                + lut3d_pkg::ADDR_SUM_W'(bi) * lut3d_pkg::ADDR_SUM_W'(dd_ff);
      ram_addr = addr_full[lut3d_pkg::ADDR_W-1:0];
   end

   lut3d_ram #(
      .WIDTH (lut3d_pkg::ENTRY_W),
      .DEPTH (lut3d_pkg::LUT_DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (cmd.issue),
      .we    (cmd.write),
      .addr  (ram_addr),
      .wdata (entry_ff),
      .rdata (rdata)
   );

   // blend pipeline valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.issue && cmd.interp;
         p1_v_ff <= rd_v_ff;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
      end
   end

   // weight products, one axis per stage, last one split in halves
   always_comb begin
      wr_sel = k1_ff[0] ? whi_ff[0] : wlo_ff[0];
      wg_sel = k2_ff[1] ? whi_ff[1] : wlo_ff[1];
      wb_sel = k3_ff[2] ? whi_ff[2] : wlo_ff[2];
      for (int c = 0; c < 3; c++) begin
         p1_in[c] = lut3d_pkg::P1_W'(rdata[c*lut3d_pkg::COLOR_BITS +: lut3d_pkg::COLOR_BITS])
                  * lut3d_pkg::P1_W'(wr_sel);
         p2_in[c] = lut3d_pkg::P2_W'(p1_ff[c]) * lut3d_pkg::P2_W'(wg_sel);
         p3lo_in[c] = lut3d_pkg::P3LO_W'(p2_ff[c][lut3d_pkg::SPLIT_W-1:0])
                    * lut3d_pkg::P3LO_W'(wb_sel);
         p3hi_in[c] = lut3d_pkg::P3HI_W'(p2_ff[c][lut3d_pkg::P2_W-1:lut3d_pkg::SPLIT_W])
                    * lut3d_pkg::P3HI_W'(wb_sel);
      end
   end

   always_ff @(posedge clock) begin
      k1_ff   <= cmd.corner;
      k2_ff   <= k1_ff;
      k3_ff   <= k2_ff;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      p3lo_ff <= p3lo_in;
      p3hi_ff <= p3hi_in;
   end

   // accumulators, low half starts at the rounding offset
   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.split) begin
            acc_lo_ff[c] <= lut3d_pkg::ACC_LO_W'(1) << (lut3d_pkg::FRAC_SHIFT - 1);
            acc_hi_ff[c] <= '0;
         end else if (p3_v_ff) begin
            acc_lo_ff[c] <= acc_lo_ff[c] + lut3d_pkg::ACC_LO_W'(p3lo_ff[c]);
            acc_hi_ff[c] <= acc_hi_ff[c] + lut3d_pkg::ACC_HI_W'(p3hi_ff[c]);
         end
      end
   end

   // final sum and result select
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         fin[c] = lut3d_pkg::FIN_W'(acc_lo_ff[c])
                + (lut3d_pkg::FIN_W'(acc_hi_ff[c]) << lut3d_pkg::SPLIT_W);
         out_in[c] = cmd.interp ?
                     fin[c][lut3d_pkg::FRAC_SHIFT +: lut3d_pkg::COLOR_BITS] :
                     rdata[c*lut3d_pkg::COLOR_BITS +: lut3d_pkg::COLOR_BITS];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff <= out_in;
      end
   end

   assign sts.pipe_empty = !(rd_v_ff || p1_v_ff || p2_v_ff || p3_v_ff);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign out_red   = out_ff[0];
   assign out_green = out_ff[1];
   assign out_blue  = out_ff[2];

endmodule

### rtl/lut3d_ctrl.sv
module lut3d_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lut3d_pkg::OP_W-1:0]    req_op,
   input  lut3d_pkg::sts_type            sts,
   output lut3d_pkg::cmd_type            cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SPLIT  = 3'd1;
   localparam logic [2:0] ST_ISSUE  = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;
   localparam logic [2:0] CORNER_LAST = 3'd7;

   logic [2:0]                   state_ff, state_in;
   logic [2:0]                   corner_ff, corner_in;
   logic [lut3d_pkg::OP_W-1:0]   op_ff, op_in;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      corner_in = corner_ff;
      op_in     = op_ff;
      req_ready = 1'b0;
      cmd          = '0;
      cmd.interp   = (op_ff == lut3d_pkg::OP_INTERP);
      cmd.corner   = corner_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               op_in        = req_op;
               if (req_op != lut3d_pkg::OP_NONE) begin
                  state_in = ST_SPLIT;
               end
            end
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            corner_in = '0;
            state_in  = ST_ISSUE;
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            cmd.write = (op_ff == lut3d_pkg::OP_WRITE);
            if (op_ff == lut3d_pkg::OP_WRITE) begin
               state_in = ST_IDLE;
            end else if (op_ff == lut3d_pkg::OP_READ) begin
               state_in = ST_FINISH;
            end else if (corner_ff == CORNER_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               corner_in = corner_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            if (sts.pipe_empty) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      corner_ff <= corner_in;
      op_ff     <= op_in;
   end

   // checks
   a_accept_split: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op != lut3d_pkg::OP_NONE) |=> (state_ff == ST_SPLIT))
      else $error("accepted transaction did not start");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result loaded over a pending result");

   a_no_write_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (op_ff != lut3d_pkg::OP_WRITE))
      else $error("write produced a result");

   a_drain_after_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (op_ff == lut3d_pkg::OP_INTERP))
      else $error("drain entered without interpolation");

endmodule

### rtl/color_lut_3d_trilinear.sv
// 3D color lookup table (17x17x17 RGB entries, Q0.12) with trilinear
// interpolation. Each transaction runs to its end before the next one is
// accepted. For an interpolation the eight corner entries come one per cycle
// from the single-port table memory and pass the weight-product pipeline
// before the rounded sum is registered. The result register lets a finished
// result wait while the next transaction starts. Table contents are
// undefined after reset until written.
module color_lut_3d_trilinear (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lut3d_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lut3d_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lut3d_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                 pready,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lut3d_pkg::OP_W-1:0]           req_op,
   input  logic [lut3d_pkg::IDX_W-1:0]          req_red_index,
   input  logic [lut3d_pkg::IDX_W-1:0]          req_green_index,
   input  logic [lut3d_pkg::IDX_W-1:0]          req_blue_index,
   input  logic [lut3d_pkg::COLOR_BITS-1:0]     req_entry_red,
   input  logic [lut3d_pkg::COLOR_BITS-1:0]     req_entry_green,
   input  logic [lut3d_pkg::COLOR_BITS-1:0]     req_entry_blue,
   input  logic [lut3d_pkg::COORD_W-1:0]        req_rel_red,
   input  logic [lut3d_pkg::COORD_W-1:0]        req_rel_green,
   input  logic [lut3d_pkg::COORD_W-1:0]        req_rel_blue,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lut3d_pkg::COLOR_BITS-1:0]     rsp_out_red,
   output logic [lut3d_pkg::COLOR_BITS-1:0]     rsp_out_green,
   output logic [lut3d_pkg::COLOR_BITS-1:0]     rsp_out_blue
);

   logic [lut3d_pkg::IDX_W-1:0] division_ff, division_in;
   lut3d_pkg::cmd_type cmd;
   lut3d_pkg::sts_type sts;
   logic csr_hit;

   // division register
   assign pready  = 1'b1;
   assign csr_hit = (paddr[lut3d_pkg::CSR_ADDR_W-1] == lut3d_pkg::REG_DIVISION);

   always_comb begin
      division_in = division_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         division_in = pwdata[lut3d_pkg::IDX_W-1:0];
      end
      prdata = csr_hit ? lut3d_pkg::CSR_DATA_W'(division_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         division_ff <= lut3d_pkg::DIVISION_RESET;
      end else begin
         division_ff <= division_in;
      end
   end

   lut3d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .sts       (sts),
      .cmd       (cmd)
   );

   lut3d_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .division    (division_ff),
      .red_index   (req_red_index),
      .green_index (req_green_index),
      .blue_index  (req_blue_index),
      .entry_red   (req_entry_red),
      .entry_green (req_entry_green),
      .entry_blue  (req_entry_blue),
      .rel_red     (req_rel_red),
      .rel_green   (req_rel_green),
      .rel_blue    (req_rel_blue),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .out_red     (rsp_out_red),
      .out_green   (rsp_out_green),
      .out_blue    (rsp_out_blue)
   );

endmodule

### tb/sv/color_lut_3d_trilinear_checker.sv
`timescale 1ns / 100ps

module color_lut_3d_trilinear_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic                                 pready,
   input  logic [lut3d_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lut3d_pkg::CSR_DATA_W-1:0]     pwdata,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [lut3d_pkg::OP_W-1:0]           req_op,
   input  logic [lut3d_pkg::IDX_W-1:0]          req_red_index,
   input  logic [lut3d_pkg::IDX_W-1:0]          req_green_index,
   input  logic [lut3d_pkg::IDX_W-1:0]          req_blue_index,
   input  logic [lut3d_pkg::COLOR_BITS-1:0]     req_entry_red,
   input  logic [lut3d_pkg::COLOR_BITS-1:0]     req_entry_green,
   input  logic [lut3d_pkg::COLOR_BITS-1:0]     req_entry_blue,
   input  logic [lut3d_pkg::COORD_W-1:0]        req_rel_red,
   input  logic [lut3d_pkg::COORD_W-1:0]        req_rel_green,
   input  logic [lut3d_pkg::COORD_W-1:0]        req_rel_blue,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [lut3d_pkg::COLOR_BITS-1:0]     rsp_out_red,
   input  logic [lut3d_pkg::COLOR_BITS-1:0]     rsp_out_green,
   input  logic [lut3d_pkg::COLOR_BITS-1:0]     rsp_out_blue,
   output int                                   fail_count,
   output int                                   pending
);

   typedef struct packed {
      logic [lut3d_pkg::COLOR_BITS-1:0] red;
      logic [lut3d_pkg::COLOR_BITS-1:0] green;
      logic [lut3d_pkg::COLOR_BITS-1:0] blue;
   } color_type;

   // shadow of the table and the division register
   color_type     color_table [lut3d_pkg::LUT_DEPTH];
   logic [4:0]    division_reg;
   color_type     color_queue [$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic int grid_points();
      int d;
      d = division_reg;
      if (d < 2) d = 2;
      if (d > lut3d_pkg::MAX_GRID) d = lut3d_pkg::MAX_GRID;
      return d;
   endfunction

   function automatic int clip_index(int v, int d);
      return (v > d - 1) ? d - 1 : v;
   endfunction

   function automatic int table_addr(int r, int g, int b, int d);
      int a;
      a = r + g * d + b * d * d;
      return (a < lut3d_pkg::LUT_DEPTH) ? a : 0;
   endfunction

   // split one coordinate into two grid points and their Q1.16 weights
   function automatic void split_axis(input logic [lut3d_pkg::COORD_W-1:0] rel, input int d,
                                      output int lo, output int hi,
                                      output longint unsigned wlo,
                                      output longint unsigned whi);
      longint unsigned q;
      longint unsigned pos;
      int base;
      q = (rel > 65536) ? 65536 : rel;
      pos = q * (d - 1);
      base = int'(pos >> 16);
      if (base >= d - 1) begin
         lo = d - 1;
         hi = d - 1;
         wlo = 65536;
         whi = 0;
      end else begin
         lo = base;
         hi = base + 1;
         whi = pos & 64'hFFFF;
         wlo = 65536 - whi;
      end
   endfunction

   // trilinear blend of the eight surrounding entries
   function automatic color_type blend_color(logic [lut3d_pkg::COORD_W-1:0] rr,
                                             logic [lut3d_pkg::COORD_W-1:0] rg,
                                             logic [lut3d_pkg::COORD_W-1:0] rb, int d);
      int idx [3][2];
      longint unsigned wt [3][2];
      longint unsigned acc [3];
      longint unsigned w;
      color_type e;
      color_type res;
      int a;
      split_axis(rr, d, idx[0][0], idx[0][1], wt[0][0], wt[0][1]);
      split_axis(rg, d, idx[1][0], idx[1][1], wt[1][0], wt[1][1]);
      split_axis(rb, d, idx[2][0], idx[2][1], wt[2][0], wt[2][1]);
      acc[0] = 0;
      acc[1] = 0;
      acc[2] = 0;
      for (int k = 0; k < 8; k++) begin
         w = wt[0][k & 1] * wt[1][(k >> 1) & 1] * wt[2][(k >> 2) & 1];
         a = table_addr(idx[0][k & 1], idx[1][(k >> 1) & 1], idx[2][(k >> 2) & 1], d);
         e = color_table[a];
         acc[0] += w * e.red;
         acc[1] += w * e.green;
         acc[2] += w * e.blue;
      end
      res.red   = lut3d_pkg::COLOR_BITS'((acc[0] + (64'd1 << 47)) >> 48);
      res.green = lut3d_pkg::COLOR_BITS'((acc[1] + (64'd1 << 47)) >> 48);
      res.blue  = lut3d_pkg::COLOR_BITS'((acc[2] + (64'd1 << 47)) >> 48);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      int d;
      int a;
      color_type got;
      color_type want;
      if (reset) begin
         division_reg = lut3d_pkg::DIVISION_RESET;
         color_queue.delete();
      end else begin
         // register writes
         if (psel && penable && pwrite && pready &&
             paddr[lut3d_pkg::CSR_ADDR_W-1] == lut3d_pkg::REG_DIVISION)
            division_reg = pwdata[4:0];
         // accepted request transaction
         if (req_valid && req_ready) begin
            d = grid_points();
            a = table_addr(clip_index(req_red_index, d), clip_index(req_green_index, d),
                           clip_index(req_blue_index, d), d);
            case (req_op)
               lut3d_pkg::OP_WRITE: begin
                  color_table[a] = {req_entry_red, req_entry_green, req_entry_blue};
               end
               lut3d_pkg::OP_READ: begin
                  color_queue.push_back(color_table[a]);
               end
               lut3d_pkg::OP_INTERP: begin
                  color_queue.push_back(blend_color(req_rel_red, req_rel_green,
                                                    req_rel_blue, d));
               end
               default: ;
            endcase
         end
         // accepted response transaction
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_red, rsp_out_green, rsp_out_blue};
            if (color_queue.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = color_queue.pop_front();
               if (got.red !== want.red) report_mismatch("red", got.red, want.red);
               if (got.green !== want.green) report_mismatch("green", got.green, want.green);
               if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
            end
         end
      end
      pending = color_queue.size();
   end

endmodule

### tb/sv/color_lut_3d_trilinear_tb.sv
`timescale 1ns / 100ps

module color_lut_3d_trilinear_tb;

   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [lut3d_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [lut3d_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [lut3d_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [lut3d_pkg::OP_W-1:0] req_op = lut3d_pkg::OP_WRITE;
   logic [lut3d_pkg::IDX_W-1:0] req_red_index = '0;
   logic [lut3d_pkg::IDX_W-1:0] req_green_index = '0;
   logic [lut3d_pkg::IDX_W-1:0] req_blue_index = '0;
   logic [lut3d_pkg::COLOR_BITS-1:0] req_entry_red = '0;
   logic [lut3d_pkg::COLOR_BITS-1:0] req_entry_green = '0;
   logic [lut3d_pkg::COLOR_BITS-1:0] req_entry_blue = '0;
   logic [lut3d_pkg::COORD_W-1:0] req_rel_red = '0;
   logic [lut3d_pkg::COORD_W-1:0] req_rel_green = '0;
   logic [lut3d_pkg::COORD_W-1:0] req_rel_blue = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [lut3d_pkg::COLOR_BITS-1:0] rsp_out_red;
   logic [lut3d_pkg::COLOR_BITS-1:0] rsp_out_green;
   logic [lut3d_pkg::COLOR_BITS-1:0] rsp_out_blue;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int tx_idle_pct = 27;
   int rx_idle_pct = 77;
   int grid = lut3d_pkg::MAX_GRID;
   bit long_stall = 1'b0;

   always #4 clock = ~clock;

   color_lut_3d_trilinear dut (.*);

   color_lut_3d_trilinear_checker checker_i (.*);

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side back pressure
   initial begin
      forever begin
         if (long_stall) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_stall = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
            @(posedge clock);
         end
      end
   end

   // one request transaction, valid left high after acceptance
   task automatic send_req(input logic [lut3d_pkg::OP_W-1:0] op, input int ri, input int gi,
                           input int bi, input logic [lut3d_pkg::COLOR_BITS-1:0] er,
                           input logic [lut3d_pkg::COLOR_BITS-1:0] eg,
                           input logic [lut3d_pkg::COLOR_BITS-1:0] eb,
                           input logic [lut3d_pkg::COORD_W-1:0] cr,
                           input logic [lut3d_pkg::COORD_W-1:0] cg,
                           input logic [lut3d_pkg::COORD_W-1:0] cb);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_red_index   <= lut3d_pkg::IDX_W'(ri);
      req_green_index <= lut3d_pkg::IDX_W'(gi);
      req_blue_index  <= lut3d_pkg::IDX_W'(bi);
      req_entry_red   <= er;
      req_entry_green <= eg;
      req_entry_blue  <= eb;
      req_rel_red     <= cr;
      req_rel_green   <= cg;
      req_rel_blue    <= cb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_entry(input int ri, input int gi, input int bi);
      send_req(lut3d_pkg::OP_WRITE, ri, gi, bi, lut3d_pkg::COLOR_BITS'($urandom),
               lut3d_pkg::COLOR_BITS'($urandom), lut3d_pkg::COLOR_BITS'($urandom),
               lut3d_pkg::COORD_W'($urandom), lut3d_pkg::COORD_W'($urandom),
               lut3d_pkg::COORD_W'($urandom));
   endtask

   task automatic read_entry(input int ri, input int gi, input int bi);
      send_req(lut3d_pkg::OP_READ, ri, gi, bi, lut3d_pkg::COLOR_BITS'($urandom),
               lut3d_pkg::COLOR_BITS'($urandom), lut3d_pkg::COLOR_BITS'($urandom),
               lut3d_pkg::COORD_W'($urandom), lut3d_pkg::COORD_W'($urandom),
               lut3d_pkg::COORD_W'($urandom));
   endtask

   task automatic interp_at(input logic [lut3d_pkg::COORD_W-1:0] cr,
                            input logic [lut3d_pkg::COORD_W-1:0] cg,
                            input logic [lut3d_pkg::COORD_W-1:0] cb);
      send_req(lut3d_pkg::OP_INTERP, $urandom_range(31), $urandom_range(31),
               $urandom_range(31), lut3d_pkg::COLOR_BITS'($urandom),
               lut3d_pkg::COLOR_BITS'($urandom), lut3d_pkg::COLOR_BITS'($urandom),
               cr, cg, cb);
   endtask

   // drain, let trailing writes settle, then program the grid size
   task automatic set_division(input int value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= lut3d_pkg::CSR_ADDR_W'(4 * lut3d_pkg::REG_DIVISION);
      pwdata  <= lut3d_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      grid = (value < 2) ? 2 : (value > lut3d_pkg::MAX_GRID) ? lut3d_pkg::MAX_GRID : value;
   endtask

   function automatic int pick_index();
      if ($urandom_range(9) == 0) return $urandom_range(31);
      return $urandom_range(grid - 1);
   endfunction

   function automatic logic [lut3d_pkg::COORD_W-1:0] pick_coord();
      case ($urandom_range(7))
         0: return '0;
         1: return lut3d_pkg::COORD_W'(65536);
         2: return lut3d_pkg::COORD_W'($urandom_range(131071));
         3: return lut3d_pkg::COORD_W'(65535);
         default: return lut3d_pkg::COORD_W'($urandom_range(65536));
      endcase
   endfunction

   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) write_entry(pick_index(), pick_index(), pick_index());
      else if (pick < 55) read_entry(pick_index(), pick_index(), pick_index());
      else if (pick < 95) interp_at(pick_coord(), pick_coord(), pick_coord());
      else send_req(lut3d_pkg::OP_NONE, pick_index(), pick_index(), pick_index(),
                    lut3d_pkg::COLOR_BITS'($urandom), lut3d_pkg::COLOR_BITS'($urandom),
                    lut3d_pkg::COLOR_BITS'($urandom), pick_coord(), pick_coord(),
                    pick_coord());
   endtask

   initial begin
      int div_list [6] = '{5, 2, 4, 0, 3, 5};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full grid: only the top corner and the origin are touched
      write_entry(16, 16, 16);
      write_entry(0, 0, 0);
      send_req(lut3d_pkg::OP_WRITE, 31, 31, 31, '1, '1, '1, '1, '1, '1);
      read_entry(16, 16, 16);
      read_entry(31, 17, 20);
      read_entry(0, 0, 0);
      interp_at(lut3d_pkg::COORD_W'(65536), lut3d_pkg::COORD_W'(65536),
                lut3d_pkg::COORD_W'(65536));
      interp_at('1, '1, '1);
      interp_at(lut3d_pkg::COORD_W'(70000), lut3d_pkg::COORD_W'(131071),
                lut3d_pkg::COORD_W'(65536));
      send_req(lut3d_pkg::OP_NONE, 5, 5, 5, '1, '1, '1, '1, '1, '1);
      set_division(31);
      read_entry(31, 31, 31);
      interp_at('1, '1, '1);

      // fill every location that grids of up to five points address
      set_division(5);
      for (int b = 0; b < 5; b++)
         for (int g = 0; g < 5; g++)
            for (int r = 0; r < 5; r++)
               write_entry(r, g, b);

      // directed: field extremes, saturation, unused opcode, coordinate corners
      send_req(lut3d_pkg::OP_WRITE, 0, 0, 0, '0, '0, '0, '0, '0, '0);
      read_entry(0, 0, 0);
      read_entry(4, 4, 4);
      read_entry(31, 0, 17);
      send_req(lut3d_pkg::OP_NONE, 3, 3, 3, '1, '1, '1, '1, '1, '1);
      read_entry(3, 3, 3);
      interp_at('0, '0, '0);
      interp_at(lut3d_pkg::COORD_W'(65536), lut3d_pkg::COORD_W'(65536),
                lut3d_pkg::COORD_W'(65536));
      interp_at('1, '1, '1);
      interp_at(lut3d_pkg::COORD_W'(65535), lut3d_pkg::COORD_W'(32768),
                lut3d_pkg::COORD_W'(1));
      set_division(17);
      read_entry(16, 6, 0);
      read_entry(4, 2, 0);
      set_division(1);
      interp_at(lut3d_pkg::COORD_W'(32768), lut3d_pkg::COORD_W'(16384),
                lut3d_pkg::COORD_W'(65535));
      read_entry(31, 1, 0);
      set_division(3);
      interp_at(lut3d_pkg::COORD_W'(21845), lut3d_pkg::COORD_W'(43690),
                lut3d_pkg::COORD_W'(65536));
      write_entry(2, 31, 1);
      read_entry(2, 2, 1);

      // random phases with changing idle mix and grid size
      for (int ph = 0; ph < 6; ph++) begin
         set_division(div_list[ph]);
         if (ph == 2) begin
            tx_idle_pct = 77;
            rx_idle_pct = 27;
         end else if (ph == 4) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         for (int n = 0; n < 50; n++) begin
            if (ph == 4 && n == 10) long_stall = 1'b1;
            random_item();
         end
      end

      // end of stimulus
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
